>>> rtl/core/btec_pkg.sv
// Shared types, constants and helpers for the boosted tree ensemble classifier.
// No dependencies; imported by the node RAM, the top level and the bench.
package btec_pkg;

    localparam int DEF_TREE_COUNT     = 16;
    localparam int DEF_NODES_PER_TREE = 256;
    localparam int DEF_FEATURE_COUNT  = 16;
    localparam int DEF_MAX_VISITS     = 64;
    localparam int CLASS_COUNT        = 3;

    // Input command codes.
    localparam logic [1:0] CMD_NODE    = 2'd0;
    localparam logic [1:0] CMD_HEADER  = 2'd1;
    localparam logic [1:0] CMD_FEATURE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_TREES = 2'd0;
    localparam logic [1:0] REG_BASE0 = 2'd1;
    localparam logic [1:0] REG_BASE1 = 2'd2;
    localparam logic [1:0] REG_BASE2 = 2'd3;

    // One stored tree node: threshold plus link word.
    typedef struct packed {
        logic [63:0] threshold;
        logic        leaf;
        logic [7:0]  feature;
        logic [15:0] left;
        logic [15:0] right;
        logic [7:0]  cls;
    } node_word_t;

    // Signed 64-bit add that clamps at the limits on overflow.
    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if ((a[63] == b[63]) && (s[63] != a[63]))
        begin
            s = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

endpackage

>>> rtl/core/boosted_tree_ensemble_classify.sv
// Top level of the boosted tree ensemble classifier: command intake, tree walk
// sequencer, score registers and result register. Depends on btec_pkg and btec_node_ram.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one command per beat: a node
//   write, a tree header write or a feature element. A feature element with last
//   set starts a classification; the block then drops in_ready until the result
//   is placed in the output register. A classification steps through the trees
//   in use: for each one it fetches the root, then walks down with one read of
//   the node RAM per node visited until a leaf, a feature index past the vector
//   or a failed link check ends the walk; the argmax over the scores comes last.
//   The output channel (out_valid/out_ready) holds one result beat in a register;
//   new commands are taken while it waits. If a new result is ready while the old
//   one is still not taken, the block waits for the receiver.
//   Configuration writes (cfg_write) are taken in any cycle and must only happen
//   while the block is idle.
//   Reset clears headers, features, scores and configuration; the node RAM is
//   not cleared and must be written before it is used.
module boosted_tree_ensemble_classify
    import btec_pkg::*;
#(
    parameter int TREE_COUNT     = DEF_TREE_COUNT,
    parameter int NODES_PER_TREE = DEF_NODES_PER_TREE,
    parameter int FEATURE_COUNT  = DEF_FEATURE_COUNT,
    parameter int MAX_VISITS     = DEF_MAX_VISITS
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [3:0]         tree_number,
    input  logic [7:0]         node_number,
    input  logic               node_leaf,
    input  logic [7:0]         node_feature,
    input  logic signed [15:0] left_link,
    input  logic signed [15:0] right_link,
    input  logic [7:0]         leaf_class,
    input  logic [8:0]         node_total,
    input  logic signed [63:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         predicted_class,
    output logic signed [63:0] winning_score
);

    localparam int DEPTH = TREE_COUNT * NODES_PER_TREE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TIW   = (TREE_COUNT > 1) ? $clog2(TREE_COUNT) : 1;
    localparam int TCW   = $clog2(TREE_COUNT + 1);
    localparam int FIW   = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
    localparam int LMW   = $clog2(NODES_PER_TREE + 1);
    localparam int VW    = $clog2(MAX_VISITS + 1);
    localparam logic [AW-1:0] NPT_A = AW'(NODES_PER_TREE);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_TREE   = 2'd1;
    localparam logic [1:0] S_NODE   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [4:0]     trees_reg;
    logic [63:0]    base_reg [CLASS_COUNT];
    logic [8:0]     size_reg [TREE_COUNT];
    logic [63:0]    weight_reg [TREE_COUNT];
    logic [63:0]    feature_reg [FEATURE_COUNT];
    logic [FIW-1:0] pos_reg;
    logic [63:0]    score_reg [CLASS_COUNT];
    logic [TCW-1:0] tree_reg;
    logic [LMW-1:0] limit_reg;
    logic [VW-1:0]  visits_reg;
    logic           out_valid_reg;
    logic [1:0]     class_reg;
    logic [63:0]    win_reg;

    logic           in_fire;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    node_word_t     ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    node_word_t     node;
    logic [TIW-1:0] tree_idx;
    logic [AW-1:0]  tree_base;
    logic           trees_done;
    logic [LMW-1:0] limit_calc;
    logic [63:0]    feat_val;
    logic           go_left;
    logic [15:0]    link;
    logic           link_ok;
    logic [1:0]     best;
    logic           out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign predicted_class = class_reg;
    assign winning_score   = win_reg;

    // Node writes go straight into the RAM.
    assign ram_we    = in_fire && (cmd == CMD_NODE) && (32'(tree_number) < TREE_COUNT)
                       && (32'(node_number) < NODES_PER_TREE);
    assign ram_waddr = AW'(tree_number) * NPT_A + AW'(node_number);
    assign ram_wdata = '{threshold: value, leaf: node_leaf, feature: node_feature,
                         left: left_link, right: right_link, cls: leaf_class};

    btec_node_ram #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(node)
    );

    // Walk datapath: current tree, its node limit and the branch decision.
    assign tree_idx   = TIW'(tree_reg);
    assign tree_base  = AW'(tree_idx) * NPT_A;
    assign trees_done = (5'(tree_reg) >= trees_reg) || (32'(tree_reg) >= TREE_COUNT);
    assign limit_calc = (32'(size_reg[tree_idx]) > NODES_PER_TREE) ?
                        LMW'(NODES_PER_TREE) : LMW'(size_reg[tree_idx]);
    assign feat_val   = feature_reg[FIW'(node.feature)];
    assign go_left    = $signed(feat_val) < $signed(node.threshold);
    assign link       = go_left ? node.left : node.right;
    assign link_ok    = !link[15] && (32'(link[14:0]) < 32'(limit_reg))
                        && (32'(visits_reg) + 1 < MAX_VISITS);

    // Read address: root of the current tree or the chosen child.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = tree_base;
        if (state_reg == S_TREE)
        begin
            ram_re = !trees_done && (limit_calc != '0);
        end
        else if (state_reg == S_NODE)
        begin
            ram_raddr = tree_base + AW'(link[14:0]);
            ram_re    = !node.leaf && (32'(node.feature) < FEATURE_COUNT) && link_ok;
        end
    end

    // Argmax over the three scores, lowest class on a tie.
    always_comb
    begin
        best = 2'd0;
        if ($signed(score_reg[0]) < $signed(score_reg[1]))
        begin
            best = 2'd1;
        end
        if ($signed(score_reg[best]) < $signed(score_reg[2]))
        begin
            best = 2'd2;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd == CMD_FEATURE) && last)
                begin
                    state_next = S_TREE;
                end
            end
            S_TREE:
            begin
                if (trees_done)
                begin
                    state_next = S_RESULT;
                end
                else if (limit_calc != '0)
                begin
                    state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                if (!ram_re)
                begin
                    state_next = S_TREE;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration, headers, features and scores.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            trees_reg     <= '0;
            pos_reg       <= '0;
            tree_reg      <= '0;
            limit_reg     <= '0;
            visits_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CLASS_COUNT; c++)
            begin
                base_reg[c]  <= '0;
                score_reg[c] <= '0;
            end
            for (int t = 0; t < TREE_COUNT; t++)
            begin
                size_reg[t]   <= '0;
                weight_reg[t] <= '0;
            end
            for (int f = 0; f < FEATURE_COUNT; f++)
            begin
                feature_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TREES: trees_reg   <= cfg_data[4:0];
                    REG_BASE0: base_reg[0] <= cfg_data;
                    REG_BASE1: base_reg[1] <= cfg_data;
                    REG_BASE2: base_reg[2] <= cfg_data;
                    default:   trees_reg   <= trees_reg;
                endcase
            end

            // Header writes and feature elements.
            if (in_fire && (cmd == CMD_HEADER) && (32'(tree_number) < TREE_COUNT))
            begin
                size_reg[TIW'(tree_number)]   <= node_total;
                weight_reg[TIW'(tree_number)] <= value;
            end
            if (in_fire && (cmd == CMD_FEATURE))
            begin
                feature_reg[pos_reg] <= value;
                if (last || (32'(pos_reg) == FEATURE_COUNT - 1))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (last)
                begin
                    tree_reg <= '0;
                    for (int c = 0; c < CLASS_COUNT; c++)
                    begin
                        score_reg[c] <= base_reg[c];
                    end
                end
            end

            // Tree setup: latch the limit and skip empty trees.
            if ((state_reg == S_TREE) && !trees_done)
            begin
                limit_reg  <= limit_calc;
                visits_reg <= '0;
                if (limit_calc == '0)
                begin
                    tree_reg <= tree_reg + 1'b1;
                end
            end

            // Node visit: follow the link, or end the walk and score the node if it is a leaf.
            if (state_reg == S_NODE)
            begin
                if (ram_re)
                begin
                    visits_reg <= visits_reg + 1'b1;
                end
                else
                begin
                    tree_reg <= tree_reg + 1'b1;
                    if (node.leaf && (32'(node.cls) < CLASS_COUNT))
                    begin
                        score_reg[2'(node.cls)] <= add_sat(score_reg[2'(node.cls)],
                                                           weight_reg[tree_idx]);
                    end
                end
            end

            // Output register.
            if ((state_reg == S_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RESULT) && out_free)
        begin
            class_reg <= best;
            win_reg   <= score_reg[best];
        end
    end

endmodule

>>> rtl/core/btec_node_ram.sv
// Single-port-write, single-port-read node table with a registered read port.
// Depends on btec_pkg for the node word type.
module btec_node_ram
    import btec_pkg::*;
#(
    parameter int DEPTH = DEF_TREE_COUNT * DEF_NODES_PER_TREE,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  node_word_t       wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output node_word_t       rdata
);

    node_word_t mem [DEPTH];
    node_word_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for boosted_tree_ensemble_classify: loads small tree ensembles,
// streams feature vectors and compares every class decision with an internal predictor.
// Depends on btec_pkg for the node word layout, command codes and register indexes.
module tb_top;
    import btec_pkg::*;

    localparam int TREES = DEF_TREE_COUNT;
    localparam int NODES = DEF_NODES_PER_TREE;
    localparam int FEATS = DEF_FEATURE_COUNT;
    localparam int VISITS = DEF_MAX_VISITS;
    localparam int RANDOM_ITEMS = 1950;
    localparam int STALL_LIMIT = 6000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // One command beat on the input channel.
    typedef struct {
        logic [1:0]  cmd;
        logic [3:0]  tree;
        logic [7:0]  node;
        logic        leaf;
        logic [7:0]  feat;
        logic [15:0] left;
        logic [15:0] right;
        logic [7:0]  cls;
        logic [8:0]  total;
        logic [63:0] val;
        logic        last;
    } beat_t;

    typedef struct {
        logic [1:0]  cls;
        logic [63:0] score;
    } decision_t;

    // Tracks the loaded ensemble and the decisions still owed by the block.
    class ensemble_scoreboard;
        node_word_t  nodes[TREES * NODES];
        bit          written[TREES * NODES];
        logic [8:0]  sizes[TREES];
        logic [63:0] weights[TREES];
        logic [63:0] feats[FEATS];
        logic [63:0] scores[CLASS_COUNT];
        logic [63:0] base[CLASS_COUNT];
        logic [4:0]  trees;
        int          fill;
        int          failures;
        int          decisions;
        decision_t   owed[$];

        function new();
            for (int i = 0; i < TREES; i++)
            begin
                sizes[i] = '0;
                weights[i] = '0;
            end
            for (int i = 0; i < FEATS; i++)
                feats[i] = '0;
            for (int i = 0; i < CLASS_COUNT; i++)
                base[i] = '0;
            trees = '0;
            fill = 0;
            failures = 0;
            decisions = 0;
        endfunction

        function int active_trees();
            return (trees > TREES) ? TREES : int'(trees);
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] data);
            if (idx == REG_TREES)
                trees = data[4:0];
            else if (idx == REG_BASE0)
                base[0] = data;
            else if (idx == REG_BASE1)
                base[1] = data;
            else
                base[2] = data;
        endfunction

        // Number of nodes written from slot 0 upward without a hole.
        function int prefix(int t);
            int n;
            n = 0;
            while (n < NODES && written[t * NODES + n])
                n++;
            return n;
        endfunction

        // A tree whose node count reaches a never-written slot must not be walked.
        function bit unsafe(int t);
            int lim;
            lim = (sizes[t] > NODES) ? NODES : int'(sizes[t]);
            return prefix(t) < lim;
        endfunction

        function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? S64_MIN : S64_MAX;
            return s[63:0];
        endfunction

        function void walk(int t);
            int lim;
            int idx;
            int visits;
            int slot;
            node_word_t n;
            logic [15:0] link;
            lim = (sizes[t] > NODES) ? NODES : int'(sizes[t]);
            idx = 0;
            visits = 0;
            while (visits < VISITS && idx < lim)
            begin
                slot = t * NODES + idx;
                n = nodes[slot];
                if (n.leaf)
                begin
                    if (n.cls < CLASS_COUNT)
                        scores[n.cls] = sat_sum(scores[n.cls], weights[t]);
                    return;
                end
                if (n.feature >= FEATS)
                    return;
                link = ($signed(feats[n.feature]) < $signed(n.threshold)) ? n.left : n.right;
                if (link[15])
                    return;
                idx = int'(link);
                visits++;
            end
        endfunction

        // Apply one accepted beat; a closing feature element owes a decision.
        function void note_beat(beat_t b);
            int slot;
            decision_t d;
            if (b.cmd == CMD_NODE)
            begin
                slot = b.tree * NODES + b.node;
                nodes[slot].threshold = b.val;
                nodes[slot].leaf = b.leaf;
                nodes[slot].feature = b.feat;
                nodes[slot].left = b.left;
                nodes[slot].right = b.right;
                nodes[slot].cls = b.cls;
                written[slot] = 1'b1;
            end
            else if (b.cmd == CMD_HEADER)
            begin
                sizes[b.tree] = b.total;
                weights[b.tree] = b.val;
            end
            else if (b.cmd == CMD_FEATURE)
            begin
                feats[fill] = b.val;
                fill = (fill + 1) % FEATS;
                if (b.last)
                begin
                    fill = 0;
                    for (int c = 0; c < CLASS_COUNT; c++)
                        scores[c] = base[c];
                    for (int t = 0; t < active_trees(); t++)
                        walk(t);
                    d.cls = 2'd0;
                    for (int c = 1; c < CLASS_COUNT; c++)
                        if ($signed(scores[d.cls]) < $signed(scores[c]))
                            d.cls = c[1:0];
                    d.score = scores[d.cls];
                    owed.push_back(d);
                end
            end
        endfunction

        function void check_result(logic [1:0] cls, logic [63:0] score);
            decision_t d;
            decisions++;
            if (owed.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result class %0d score %0d", cls, $signed(score));
                return;
            end
            d = owed.pop_front();
            if (cls !== d.cls || score !== d.score)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result %0d: class %0d score %0d, expected class %0d score %0d",
                             decisions, cls, $signed(score), d.cls, $signed(d.score));
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         cmd;
    logic [3:0]         tree_number;
    logic [7:0]         node_number;
    logic               node_leaf;
    logic [7:0]         node_feature;
    logic signed [15:0] left_link;
    logic signed [15:0] right_link;
    logic [7:0]         leaf_class;
    logic [8:0]         node_total;
    logic signed [63:0] value;
    logic               last;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         predicted_class;
    logic signed [63:0] winning_score;

    ensemble_scoreboard sb = new();
    int beats_sent = 0;
    int vectors_sent = 0;
    int phases_run = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    int ready_mode = 0;
    int ready_left = 0;

    boosted_tree_ensemble_classify DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .tree_number(tree_number), .node_number(node_number),
        .node_leaf(node_leaf), .node_feature(node_feature),
        .left_link(left_link), .right_link(right_link), .leaf_class(leaf_class),
        .node_total(node_total), .value(value), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .predicted_class(predicted_class), .winning_score(winning_score)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result checking and the receiver's stall pattern.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(predicted_class, winning_score);
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(1, 40);
        end
        ready_left--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 2) != 0);
            2: out_ready <= ready_left[0];
            default: out_ready <= 1'b0;
        endcase
    end

    // Watchdog on cycles without any beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one beat and hold it until accepted; bursts may end in random gaps.
    task automatic send(beat_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= b.cmd;
        tree_number <= b.tree;
        node_number <= b.node;
        node_leaf <= b.leaf;
        node_feature <= b.feat;
        left_link <= b.left;
        right_link <= b.right;
        leaf_class <= b.cls;
        node_total <= b.total;
        value <= b.val;
        last <= b.last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_beat(b);
        if (b.cmd != CMD_UNUSED)
            beats_sent++;
    endtask

    // Hold off the sender until every decision is back and the block is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_config(logic [4:0] trees, logic [63:0] b0, logic [63:0] b1,
                                logic [63:0] b2);
        logic [63:0] data[4];
        data = '{{59'd0, trees}, b0, b1, b2};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data <= data[i];
            @(posedge clk);
            sb.set_reg(i[1:0], data[i]);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic beat_t blank(logic [1:0] c);
        beat_t b;
        b = '{cmd: c, tree: 0, node: 0, leaf: 0, feat: 0, left: 0, right: 0, cls: 0,
              total: 0, val: 0, last: 0};
        return b;
    endfunction

    function automatic beat_t node_beat(int t, int n, bit leaf, int f, int l, int r, int c,
                                        logic [63:0] thr);
        beat_t b;
        b = blank(CMD_NODE);
        b.tree = 4'(t);
        b.node = 8'(n);
        b.leaf = leaf;
        b.feat = 8'(f);
        b.left = 16'(l);
        b.right = 16'(r);
        b.cls = 8'(c);
        b.val = thr;
        return b;
    endfunction

    function automatic beat_t header_beat(int t, int total, logic [63:0] w);
        beat_t b;
        b = blank(CMD_HEADER);
        b.tree = 4'(t);
        b.total = 9'(total);
        b.val = w;
        return b;
    endfunction

    function automatic beat_t feature_beat(logic [63:0] v, bit fin);
        beat_t b;
        b = blank(CMD_FEATURE);
        b.val = v;
        b.last = fin;
        return b;
    endfunction

    // Mostly small signed numbers so that compares go both ways, plus extremes.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return S64_MAX;
            2: return S64_MIN;
            3: return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 62'd0} + 64'($urandom_range(0, 9));
            default: return 64'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic logic [15:0] pick_link();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 22));
        endcase
    endfunction

    function automatic beat_t random_node();
        return node_beat($urandom_range(0, TREES - 1),
                         ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 19),
                         $urandom_range(0, 4) < 2,
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, FEATS - 1),
                         int'(pick_link()), int'(pick_link()),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 2),
                         pick_value());
    endfunction

    // Trees in use only get node counts covered by written slots.
    function automatic beat_t random_header();
        int t;
        int p;
        int total;
        t = $urandom_range(0, TREES - 1);
        p = sb.prefix(t);
        if (t >= sb.active_trees() && $urandom_range(0, 2) == 0)
            total = $urandom_range(0, 511);
        else
            case ($urandom_range(0, 3))
                0: total = 0;
                1: total = $urandom_range(0, p);
                default: total = (p == NODES) ? $urandom_range(NODES, 511) : p;
            endcase
        return header_beat(t, total, pick_value());
    endfunction

    task automatic send_vector(int n);
        for (int i = 0; i < n; i++)
            send(feature_beat(pick_value(), i == n - 1));
        vectors_sent++;
    endtask

    // Bring trees that are now in use back to a node count that is fully written.
    task automatic repair_headers();
        for (int t = 0; t < sb.active_trees(); t++)
            if (sb.unsafe(t))
                send(header_beat(t, sb.prefix(t), pick_value()));
    endtask

    task automatic directed_part();
        write_config(5'd6, 64'd0, 64'd0, 64'd0);
        // A two-way split on feature 0, then a single-leaf tree.
        send(node_beat(0, 0, 0, 0, 1, 2, 0, 64'd0));
        send(node_beat(0, 1, 1, 0, 0, 0, 0, 64'd0));
        send(node_beat(0, 2, 1, 0, 0, 0, 2, 64'd0));
        send(header_beat(0, 3, 64'd5));
        send(node_beat(1, 0, 1, 0, 0, 0, 1, 64'd0));
        send(header_beat(1, 1, 64'd7));
        // A node that loops on itself runs into the visit limit.
        send(node_beat(2, 0, 0, FEATS - 1, 0, 0, 0, S64_MAX));
        send(header_beat(2, 1, 64'd100));
        // A leaf with a class beyond the last one scores nothing.
        send(node_beat(3, 0, 1, 0, 0, 0, 255, 64'd0));
        send(header_beat(3, 1, S64_MAX));
        // Negative link on the left, out-of-range link on the right.
        send(node_beat(4, 0, 0, 1, 16'hFFFF, 16'h7FFF, 0, 64'd0));
        send(header_beat(4, 1, S64_MIN));
        // A feature index past the vector ends the walk.
        send(node_beat(5, 0, 0, 255, 0, 0, 0, 64'd0));
        send(header_beat(5, 1, 64'd3));
        // Oversized node count on a tree that is not walked, and an unused command.
        send(node_beat(9, 255, 1, 0, 0, 0, 1, S64_MIN));
        send(header_beat(9, 300, 64'd1));
        send(blank(CMD_UNUSED));
        send(feature_beat(64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send(feature_beat(S64_MIN, 1'b0));
        send(feature_beat(S64_MAX, 1'b1));
        send_vector(18);
        drain();
    endtask

    // Random phases: each starts idle with new registers, then mixes loads and vectors.
    task automatic random_part();
        logic [4:0] tsel;
        logic [63:0] bases[3];
        int goal;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: tsel = 5'd16;
                1: tsel = 5'd31;
                2: tsel = 5'd1;
                3: tsel = 5'd0;
                4: tsel = 5'd17;
                default: tsel = 5'($urandom_range(0, 31));
            endcase
            for (int c = 0; c < 3; c++)
                bases[c] = (ph == 5) ? ((c == 1) ? S64_MAX : S64_MIN) : pick_value();
            write_config(tsel, bases[0], bases[1], bases[2]);
            repair_headers();
            goal = beats_sent + RANDOM_ITEMS / 8;
            while (beats_sent < goal)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: send(random_node());
                    7, 8: send(random_header());
                    9: send(blank(CMD_UNUSED));
                    10, 11: send_vector($urandom_range(1, 15));
                    12: send_vector($urandom_range(17, 34));
                    default: send_vector(FEATS);
                endcase
            end
            drain();
            phases_run++;
        end
    endtask

    // Reset, stimulus, and the final report.
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_TREES;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_NODE;
        tree_number = '0;
        node_number = '0;
        node_leaf = 1'b0;
        node_feature = '0;
        left_link = '0;
        right_link = '0;
        leaf_class = '0;
        node_total = '0;
        value = '0;
        last = 1'b0;
        out_ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        random_part();
        drain();
        repeat (50) @(posedge clk);
        $display("Summary: %0d beats, %0d feature vectors, %0d decisions checked, %0d phases.",
                 beats_sent, vectors_sent, sb.decisions, phases_run + 1);
        $display("Mismatches and unexpected results: %0d", sb.failures);
        if (sb.failures == 0 && sb.owed.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
